FILE: design/wlbm_pkg.sv
// Package for the windowed layer blend mixer: register indexes, effect codes,
// layer bits and the per-channel color arithmetic.
// Used by wlbm_layer_sel and windowed_layer_blend_mixer; depends on nothing.
package wlbm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WIN_ENABLE     = 3'd0,
    CFG_WIN_VBOUNDS    = 3'd1,
    CFG_WIN_IN_MASKS   = 3'd2,
    CFG_WIN_OUT_MASKS  = 3'd3,
    CFG_BLEND_CTRL     = 3'd4,
    CFG_BLEND_WEIGHTS  = 3'd5,
    CFG_BRIGHT_WEIGHT  = 3'd6,
    CFG_BACKDROP       = 3'd7
  } cfg_idx_e;

  // Color effect selected by blend control bits 7..6
  typedef enum logic [1:0] {
    FX_NONE     = 2'd0,
    FX_ALPHA    = 2'd1,
    FX_BRIGHTEN = 2'd2,
    FX_DARKEN   = 2'd3
  } fx_e;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ColorW = 15;
  localparam int unsigned ChanW  = 5;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned LayerW = 6;

  // One-hot layer codes, as in the mask and target fields
  localparam logic [LayerW-1:0] LAYER_BG0      = 6'h01;
  localparam logic [LayerW-1:0] LAYER_BG1      = 6'h02;
  localparam logic [LayerW-1:0] LAYER_BG2      = 6'h04;
  localparam logic [LayerW-1:0] LAYER_SPRITE   = 6'h10;
  localparam logic [LayerW-1:0] LAYER_BACKDROP = 6'h20;

  localparam int unsigned MaskFxBit   = 5;
  localparam int unsigned SemiTranBit = 16;

  localparam logic [7:0]       BACKDROP_PRI  = 8'h30;
  localparam logic [7:0]       WIN_WRAP_MIN  = 8'hE8;
  localparam logic [4:0]       WEIGHT_MAX    = 5'd16;
  localparam logic [ChanW-1:0] CHAN_MAX      = 5'h1F;

  // Result of layer selection, handed to the effect stage
  typedef struct packed {
    logic [WordW-1:0]  color;     // chosen top word
    logic [LayerW-1:0] top;       // one-hot code of the top layer
    logic [WordW-1:0]  back_st;   // blend partner for a semi-transparent top word, from BG0..BG2 or the backdrop
    logic [LayerW-1:0] top2_st;
    logic [WordW-1:0]  back_fx;   // second layer for the regular alpha effect
    logic [LayerW-1:0] top2_fx;
    logic              fx_en;     // window allows effects
  } sel_t;

  // Weight field clamped to 16
  function automatic logic [4:0] clamp_weight(input logic [4:0] w);
    return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
  endfunction

  // Vertical window membership for one window
  function automatic logic vert_inside(input logic [15:0] bounds, input logic [7:0] line);
    logic [7:0] t;
    logic [7:0] b;
    logic       hit;
    t   = bounds[15:8];
    b   = bounds[7:0];
    hit = (t == b) && (t >= WIN_WRAP_MIN);
    if (b >= t) begin
      hit = hit || ((line >= t) && (line < b));
    end else begin
      hit = hit || (line >= t) || (line < b);
    end
    return hit;
  endfunction

  // Weighted sum per channel, >>4, saturated at 31
  function automatic logic [ColorW-1:0] alpha_mix(input logic [ColorW-1:0] a,
                                                  input logic [ColorW-1:0] b,
                                                  input logic [4:0] wa,
                                                  input logic [4:0] wb);
    logic [ColorW-1:0] res;
    logic [10:0]       sum;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      sum = 11'(a[c*ChanW +: ChanW] * wa) + 11'(b[c*ChanW +: ChanW] * wb);
      res[c*ChanW +: ChanW] = (sum[10:4] > 7'(CHAN_MAX)) ? CHAN_MAX : sum[8:4];
    end
    return res;
  endfunction

  // Brighten (up) or darken per channel
  function automatic logic [ColorW-1:0] light_mix(input logic [ColorW-1:0] c,
                                                  input logic [4:0] w,
                                                  input logic up);
    logic [ColorW-1:0] res;
    logic [ChanW-1:0]  v;
    logic [9:0]        prod;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      v = c[k*ChanW +: ChanW];
      if (up) begin
        prod = 10'(CHAN_MAX - v) * 10'(w);
        res[k*ChanW +: ChanW] = v + prod[8:4];
      end else begin
        prod = 10'(v) * 10'(w);
        res[k*ChanW +: ChanW] = v - prod[8:4];
      end
    end
    return res;
  endfunction

endpackage

FILE: design/windowed_layer_blend_mixer.sv
// Top level of the windowed layer blend mixer: config registers, input
// register, effect logic and result register. Uses wlbm_pkg, wlbm_layer_sel.
//
// Usage:
//  - Pixel channel: in_valid_i / in_stall_o with one port per pixel field.
//    A beat moves on a rising edge with valid high and stall low.
//  - Result channel: out_valid_o / out_stall_i, carrying mixed_pixel_o,
//    either the chosen layer word or an RGB555 effect result in bits 14..0.
//  - Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and
//    cfg_data_i; ready is always high and each write is registered.
//  - Path: an accepted beat passes the input register, then the mixing
//    logic and the result register, before it reaches the output.
//  - Throughput: one pixel per cycle while the receiver does not stall;
//    the whole mix is one pass of logic between the two registers.
//  - Stall: the two-entry pipe keeps filling while the receiver stalls;
//    in_stall_o rises only once both registers hold a pixel.
//  - Reset: all config registers clear to zero and the pipe empties.
module windowed_layer_blend_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  scanline_i,
  input  logic [31:0] bg0_word_i,
  input  logic [31:0] bg1_word_i,
  input  logic [31:0] bg2_word_i,
  input  logic [31:0] sprite_word_i,
  input  logic        in_object_window_i,
  input  logic        in_win0_column_i,
  input  logic        in_win1_column_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] mixed_pixel_o,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Config registers
  logic [1:0]  win_enable_q;
  logic [31:0] win_vbounds_q;
  logic [15:0] win_in_masks_q;
  logic [15:0] win_out_masks_q;
  logic [13:0] blend_ctrl_q;
  logic [15:0] blend_weights_q;
  logic [4:0]  bright_weight_q;
  logic [14:0] backdrop_q;

  // Pipe registers
  logic        s1_valid_q;
  logic        s2_valid_q;
  logic        s1_en;
  logic        s2_en;
  logic [7:0]  scanline_q;
  logic [31:0] bg0_q;
  logic [31:0] bg1_q;
  logic [31:0] bg2_q;
  logic [31:0] sprite_q;
  logic        objwin_q;
  logic        col0_q;
  logic        col1_q;
  logic [31:0] mixed_q;
  logic [31:0] mixed_d;

  wlbm_pkg::sel_t sel;
  wlbm_pkg::fx_e  mode;
  logic [4:0]     wa;
  logic [4:0]     wb;
  logic [4:0]     wy;
  logic [5:0]     first_tgt;
  logic [5:0]     second_tgt;
  logic           top_first;

  assign cfg_ready_o = 1'b1;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_enable_q    <= '0;
      win_vbounds_q   <= '0;
      win_in_masks_q  <= '0;
      win_out_masks_q <= '0;
      blend_ctrl_q    <= '0;
      blend_weights_q <= '0;
      bright_weight_q <= '0;
      backdrop_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (wlbm_pkg::cfg_idx_e'(cfg_index_i))
        wlbm_pkg::CFG_WIN_ENABLE:    win_enable_q    <= cfg_data_i[1:0];
        wlbm_pkg::CFG_WIN_VBOUNDS:   win_vbounds_q   <= cfg_data_i;
        wlbm_pkg::CFG_WIN_IN_MASKS:  win_in_masks_q  <= cfg_data_i[15:0];
        wlbm_pkg::CFG_WIN_OUT_MASKS: win_out_masks_q <= cfg_data_i[15:0];
        wlbm_pkg::CFG_BLEND_CTRL:    blend_ctrl_q    <= cfg_data_i[13:0];
        wlbm_pkg::CFG_BLEND_WEIGHTS: blend_weights_q <= cfg_data_i[15:0];
        wlbm_pkg::CFG_BRIGHT_WEIGHT: bright_weight_q <= cfg_data_i[4:0];
        wlbm_pkg::CFG_BACKDROP:      backdrop_q      <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Pipe advance: each stage moves when the one after it can take the beat
  assign s2_en      = !s2_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      scanline_q <= scanline_i;
      bg0_q      <= bg0_word_i;
      bg1_q      <= bg1_word_i;
      bg2_q      <= bg2_word_i;
      sprite_q   <= sprite_word_i;
      objwin_q   <= in_object_window_i;
      col0_q     <= in_win0_column_i;
      col1_q     <= in_win1_column_i;
    end
  end

  wlbm_layer_sel u_sel (
    .scanline_i         (scanline_q),
    .bg0_word_i         (bg0_q),
    .bg1_word_i         (bg1_q),
    .bg2_word_i         (bg2_q),
    .sprite_word_i      (sprite_q),
    .in_object_window_i (objwin_q),
    .in_win0_column_i   (col0_q),
    .in_win1_column_i   (col1_q),
    .win_enable_i       (win_enable_q),
    .win_vbounds_i      (win_vbounds_q),
    .win_in_masks_i     (win_in_masks_q),
    .win_out_masks_i    (win_out_masks_q),
    .backdrop_color_i   (backdrop_q),
    .sel_o              (sel)
  );

  assign mode       = wlbm_pkg::fx_e'(blend_ctrl_q[7:6]);
  assign first_tgt  = blend_ctrl_q[5:0];
  assign second_tgt = blend_ctrl_q[13:8];
  assign wa         = wlbm_pkg::clamp_weight(blend_weights_q[4:0]);
  assign wb         = wlbm_pkg::clamp_weight(blend_weights_q[12:8]);
  assign wy         = wlbm_pkg::clamp_weight(bright_weight_q);
  assign top_first  = (first_tgt & sel.top) != '0;

  // Effect: semi-transparent top word blend first, then the window effect
  always_comb begin
    mixed_d = sel.color;
    if (sel.color[wlbm_pkg::SemiTranBit]) begin
      priority if ((sel.top2_st & second_tgt) != '0) begin
        mixed_d = {17'd0, wlbm_pkg::alpha_mix(sel.color[14:0], sel.back_st[14:0], wa, wb)};
      end else if (mode == wlbm_pkg::FX_BRIGHTEN && top_first) begin
        mixed_d = {17'd0, wlbm_pkg::light_mix(sel.color[14:0], wy, 1'b1)};
      end else if (mode == wlbm_pkg::FX_DARKEN && top_first) begin
        mixed_d = {17'd0, wlbm_pkg::light_mix(sel.color[14:0], wy, 1'b0)};
      end else begin
        mixed_d = sel.color;
      end
    end else if (sel.fx_en && top_first) begin
      unique case (mode)
        wlbm_pkg::FX_ALPHA: begin
          if ((sel.top2_fx & second_tgt) != '0) begin
            mixed_d = {17'd0,
                       wlbm_pkg::alpha_mix(sel.color[14:0], sel.back_fx[14:0], wa, wb)};
          end
        end
        wlbm_pkg::FX_BRIGHTEN: mixed_d = {17'd0, wlbm_pkg::light_mix(sel.color[14:0], wy, 1'b1)};
        wlbm_pkg::FX_DARKEN:   mixed_d = {17'd0, wlbm_pkg::light_mix(sel.color[14:0], wy, 1'b0)};
        wlbm_pkg::FX_NONE:     mixed_d = sel.color;
        default:               mixed_d = sel.color;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      mixed_q <= mixed_d;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign mixed_pixel_o = mixed_q;

endmodule

FILE: design/wlbm_layer_sel.sv
// Window mask decode and layer priority selection for one pixel.
// Pure logic between the input register and the effect stage; uses wlbm_pkg.
module wlbm_layer_sel (
  input  logic [7:0]  scanline_i,
  input  logic [31:0] bg0_word_i,
  input  logic [31:0] bg1_word_i,
  input  logic [31:0] bg2_word_i,
  input  logic [31:0] sprite_word_i,
  input  logic        in_object_window_i,
  input  logic        in_win0_column_i,
  input  logic        in_win1_column_i,
  input  logic [1:0]  win_enable_i,
  input  logic [31:0] win_vbounds_i,
  input  logic [15:0] win_in_masks_i,
  input  logic [15:0] win_out_masks_i,
  input  logic [14:0] backdrop_color_i,
  output wlbm_pkg::sel_t sel_o
);

  localparam logic [wlbm_pkg::LayerW-1:0] LayerBit [4] = '{
    wlbm_pkg::LAYER_BG0, wlbm_pkg::LAYER_BG1, wlbm_pkg::LAYER_BG2, wlbm_pkg::LAYER_SPRITE
  };

  logic [31:0] lay [4];
  logic [31:0] backdrop;
  logic        w0;
  logic        w1;
  logic [7:0]  mask;
  logic [31:0] color;
  logic [wlbm_pkg::LayerW-1:0] top;

  // Layer under the top one, by priority byte, enabled layers only
  function automatic logic [37:0] find_back(input logic [31:0] l0, input logic [31:0] l1,
                                            input logic [31:0] l2, input logic [31:0] l3,
                                            input logic [31:0] bd, input logic [7:0] m,
                                            input logic [5:0] skip, input logic with_obj);
    logic [31:0] back;
    logic [5:0]  t2;
    logic [31:0] cand [4];
    back    = bd;
    t2      = wlbm_pkg::LAYER_BACKDROP;
    cand[0] = l0;
    cand[1] = l1;
    cand[2] = l2;
    cand[3] = l3;
    for (int i = 0; i < 4; i++) begin
      if ((i < 3 || with_obj) && ((m[5:0] & LayerBit[i]) != '0) &&
          (cand[i][31:24] < back[31:24]) && (skip != LayerBit[i])) begin
        back = cand[i];
        t2   = LayerBit[i];
      end
    end
    return {t2, back};
  endfunction

  assign lay[0]   = bg0_word_i;
  assign lay[1]   = bg1_word_i;
  assign lay[2]   = bg2_word_i;
  assign lay[3]   = sprite_word_i;
  assign backdrop = {wlbm_pkg::BACKDROP_PRI, 9'd0, backdrop_color_i};

  // Vertical window tests
  assign w0 = win_enable_i[0] && wlbm_pkg::vert_inside(win_vbounds_i[15:0], scanline_i);
  assign w1 = win_enable_i[1] && wlbm_pkg::vert_inside(win_vbounds_i[31:16], scanline_i);

  // Window mask: win0 over win1 over object window over outside
  always_comb begin
    priority if (w0 && in_win0_column_i) begin
      mask = win_in_masks_i[7:0];
    end else if (w1 && in_win1_column_i) begin
      mask = win_in_masks_i[15:8];
    end else if (in_object_window_i) begin
      mask = win_out_masks_i[15:8];
    end else begin
      mask = win_out_masks_i[7:0];
    end
  end

  // Top layer; BG0 compares the whole word
  always_comb begin
    color = backdrop;
    top   = wlbm_pkg::LAYER_BACKDROP;
    if ((lay[0] < color) && mask[0]) begin
      color = lay[0];
      top   = wlbm_pkg::LAYER_BG0;
    end
    if ((lay[1][31:24] < color[31:24]) && mask[1]) begin
      color = lay[1];
      top   = wlbm_pkg::LAYER_BG1;
    end
    if ((lay[2][31:24] < color[31:24]) && mask[2]) begin
      color = lay[2];
      top   = wlbm_pkg::LAYER_BG2;
    end
    if ((lay[3][31:24] < color[31:24]) && mask[4]) begin
      color = lay[3];
      top   = wlbm_pkg::LAYER_SPRITE;
    end
  end

  assign sel_o.color = color;
  assign sel_o.top   = top;
  assign sel_o.fx_en = mask[wlbm_pkg::MaskFxBit];
  assign {sel_o.top2_st, sel_o.back_st} =
    find_back(lay[0], lay[1], lay[2], lay[3], backdrop, mask, '0, 1'b0);
  assign {sel_o.top2_fx, sel_o.back_fx} =
    find_back(lay[0], lay[1], lay[2], lay[3], backdrop, mask, top, 1'b1);

endmodule

FILE: test/tb_windowed_layer_blend_mixer.sv
`timescale 1ns / 100ps
// Testbench for windowed_layer_blend_mixer: random and directed pixels against a
// built-in compositor model, checked beat by beat. Depends on wlbm_pkg and the RTL.
module tb_windowed_layer_blend_mixer;
  import wlbm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [LayerW-1:0] NO_LAYER = 6'h00;

  typedef struct packed {
    logic [7:0]  scanline;
    logic [31:0] bg0;
    logic [31:0] bg1;
    logic [31:0] bg2;
    logic [31:0] sprite;
    logic        obj_win;
    logic        win1_col;
    logic        win0_col;
  } pixel_t;

  typedef struct packed {
    logic [1:0]  win_enable;
    logic [31:0] win_vbounds;
    logic [15:0] win_in_masks;
    logic [15:0] win_out_masks;
    logic [13:0] blend_ctrl;
    logic [15:0] blend_weights;
    logic [4:0]  bright_weight;
    logic [14:0] backdrop;
  } mixer_cfg_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  scanline_i = '0;
  logic [31:0] bg0_word_i = '0;
  logic [31:0] bg1_word_i = '0;
  logic [31:0] bg2_word_i = '0;
  logic [31:0] sprite_word_i = '0;
  logic        in_object_window_i = 1'b0;
  logic        in_win0_column_i = 1'b0;
  logic        in_win1_column_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] mixed_pixel_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CFG_WIN_ENABLE;
  logic [31:0] cfg_data_i = '0;

  pixel_t      pending_pixels[$];
  logic [31:0] expected_pixels[$];
  mixer_cfg_t  mix_cfg = '0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned sent_count = 0;
  int unsigned quiet_cycles = 0;

  windowed_layer_blend_mixer u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .scanline_i         (scanline_i),
    .bg0_word_i         (bg0_word_i),
    .bg1_word_i         (bg1_word_i),
    .bg2_word_i         (bg2_word_i),
    .sprite_word_i      (sprite_word_i),
    .in_object_window_i (in_object_window_i),
    .in_win0_column_i   (in_win0_column_i),
    .in_win1_column_i   (in_win1_column_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .mixed_pixel_o      (mixed_pixel_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Compositor model
  // ---------------------------------------------------------------------------

  function automatic logic [4:0] weight_of(input logic [4:0] w);
    return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
  endfunction

  // top <= row < bottom, wrapped when top > bottom, always hit for high equal bounds
  function automatic logic in_window_rows(input logic [15:0] bounds, input logic [7:0] row);
    logic [7:0] top_row;
    logic [7:0] bot_row;
    top_row = bounds[15:8];
    bot_row = bounds[7:0];
    if (top_row == bot_row && top_row >= WIN_WRAP_MIN) return 1'b1;
    if (bot_row >= top_row) return (row >= top_row) && (row < bot_row);
    return (row >= top_row) || (row < bot_row);
  endfunction

  function automatic logic [31:0] alpha_blend(input logic [31:0] a, input logic [31:0] b,
                                              input logic [4:0] wa, input logic [4:0] wb);
    logic [31:0] res;
    int unsigned ca;
    int unsigned cb;
    int unsigned sum;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      ca  = a[k*ChanW +: ChanW];
      cb  = b[k*ChanW +: ChanW];
      sum = (ca * wa + cb * wb) >> 4;
      if (sum > 31) sum = 31;
      res[k*ChanW +: ChanW] = 5'(sum);
    end
    return res;
  endfunction

  // brighten toward white or darken toward black, per channel
  function automatic logic [31:0] shade(input logic [31:0] c, input logic [4:0] w,
                                        input logic up);
    logic [31:0] res;
    int unsigned v;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      v = c[k*ChanW +: ChanW];
      if (up) v = v + (((31 - v) * w) >> 4);
      else v = v - ((v * w) >> 4);
      res[k*ChanW +: ChanW] = 5'(v);
    end
    return res;
  endfunction

  // Highest enabled layer under the top one, by priority byte
  function automatic logic [LayerW-1:0] layer_below(input logic [3:0][31:0] lay,
                                                    input logic [7:0] mask,
                                                    input logic [31:0] backdrop,
                                                    input logic [LayerW-1:0] skip,
                                                    input logic with_sprite,
                                                    output logic [31:0] back);
    logic [3:0][LayerW-1:0] code;
    logic [LayerW-1:0]      found;
    code  = {LAYER_SPRITE, LAYER_BG2, LAYER_BG1, LAYER_BG0};
    back  = backdrop;
    found = LAYER_BACKDROP;
    for (int i = 0; i < 4; i++) begin
      if ((i < 3 || with_sprite) && (mask[LayerW-1:0] & code[i]) != 0 &&
          lay[i][31:24] < back[31:24] && skip != code[i]) begin
        back  = lay[i];
        found = code[i];
      end
    end
    return found;
  endfunction

  function automatic logic [31:0] composite_pixel(input pixel_t px, input mixer_cfg_t c);
    logic [3:0][31:0]  lay;
    logic [31:0]       backdrop;
    logic [31:0]       color;
    logic [31:0]       back;
    logic [7:0]        mask;
    logic [LayerW-1:0] top;
    logic [LayerW-1:0] below;
    logic [LayerW-1:0] first_tgt;
    logic [LayerW-1:0] second_tgt;
    logic [4:0]        wa;
    logic [4:0]        wb;
    logic [4:0]        wy;
    logic              in_w0;
    logic              in_w1;
    fx_e               fx;
    lay        = {px.sprite, px.bg2, px.bg1, px.bg0};
    backdrop   = {BACKDROP_PRI, 9'd0, c.backdrop};
    first_tgt  = c.blend_ctrl[5:0];
    second_tgt = c.blend_ctrl[13:8];
    fx         = fx_e'(c.blend_ctrl[7:6]);
    wa         = weight_of(c.blend_weights[4:0]);
    wb         = weight_of(c.blend_weights[12:8]);
    wy         = weight_of(c.bright_weight);
    in_w0      = c.win_enable[0] && in_window_rows(c.win_vbounds[15:0], px.scanline);
    in_w1      = c.win_enable[1] && in_window_rows(c.win_vbounds[31:16], px.scanline);

    // window 0 beats window 1, which beats the object window
    if (in_w0 && px.win0_col) mask = c.win_in_masks[7:0];
    else if (in_w1 && px.win1_col) mask = c.win_in_masks[15:8];
    else if (px.obj_win) mask = c.win_out_masks[15:8];
    else mask = c.win_out_masks[7:0];

    // top layer; BG0 competes on its whole word
    color = backdrop;
    top   = LAYER_BACKDROP;
    if (mask[0] && px.bg0 < color) begin
      color = px.bg0;
      top   = LAYER_BG0;
    end
    if (mask[1] && px.bg1[31:24] < color[31:24]) begin
      color = px.bg1;
      top   = LAYER_BG1;
    end
    if (mask[2] && px.bg2[31:24] < color[31:24]) begin
      color = px.bg2;
      top   = LAYER_BG2;
    end
    if (mask[4] && px.sprite[31:24] < color[31:24]) begin
      color = px.sprite;
      top   = LAYER_SPRITE;
    end

    // semi-transparent words ignore the window effect bit
    if (color[SemiTranBit]) begin
      below = layer_below(lay, mask, backdrop, NO_LAYER, 1'b0, back);
      if ((below & second_tgt) != 0) color = alpha_blend(color, back, wa, wb);
      else if (fx == FX_BRIGHTEN && (first_tgt & top) != 0) color = shade(color, wy, 1'b1);
      else if (fx == FX_DARKEN && (first_tgt & top) != 0) color = shade(color, wy, 1'b0);
    end else if (mask[MaskFxBit] && (first_tgt & top) != 0) begin
      case (fx)
        FX_ALPHA: begin
          below = layer_below(lay, mask, backdrop, top, 1'b1, back);
          if ((below & second_tgt) != 0) color = alpha_blend(color, back, wa, wb);
        end
        FX_BRIGHTEN: color = shade(color, wy, 1'b1);
        FX_DARKEN:   color = shade(color, wy, 1'b0);
        default: ;
      endcase
    end
    return color;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_gap(input int unsigned calm_left);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_left != 0 || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // priority byte biased toward the range that competes with the backdrop
  function automatic logic [31:0] random_layer_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: w[31:24] = 8'($urandom_range(0, 8'h3F));
      4:          w[31:24] = BACKDROP_PRI;
      default: ;
    endcase
    w[SemiTranBit] = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.scanline = 8'($urandom_range(0, 255));
    px.bg0      = random_layer_word();
    px.bg1      = random_layer_word();
    px.bg2      = random_layer_word();
    px.sprite   = random_layer_word();
    {px.obj_win, px.win1_col, px.win0_col} = 3'($urandom_range(0, 7));
    return px;
  endfunction

  function automatic logic [15:0] random_bounds();
    logic [7:0] t;
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: begin
        t = 8'($urandom_range(0, 200));
        b = 8'($urandom_range(t + 1, 255));
      end
      1: begin
        b = 8'($urandom_range(0, 100));
        t = 8'($urandom_range(b + 1, 255));
      end
      2: begin
        t = 8'($urandom_range(WIN_WRAP_MIN, 255));
        b = t;
      end
      3: begin
        t = 8'($urandom_range(0, WIN_WRAP_MIN - 1));
        b = t;
      end
      default: {t, b} = 16'($urandom());
    endcase
    return {t, b};
  endfunction

  function automatic mixer_cfg_t random_settings(input fx_e fx);
    mixer_cfg_t c;
    c.win_enable    = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'b11;
    c.win_vbounds   = {random_bounds(), random_bounds()};
    c.win_in_masks  = 16'($urandom());
    c.win_out_masks = 16'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      c.win_in_masks  = c.win_in_masks | 16'h2020;
      c.win_out_masks = c.win_out_masks | 16'h2020;
    end
    c.blend_ctrl      = 14'($urandom());
    c.blend_ctrl[7:6] = fx;
    c.blend_weights   = 16'($urandom());
    c.bright_weight   = 5'($urandom_range(0, 31));
    c.backdrop        = 15'($urandom());
    return c;
  endfunction

  function automatic mixer_cfg_t settings_of(input logic [1:0] en, input logic [31:0] vb,
                                             input logic [15:0] im, input logic [15:0] om,
                                             input logic [13:0] bc, input logic [15:0] bw,
                                             input logic [4:0] br, input logic [14:0] bd);
    mixer_cfg_t c;
    c.win_enable    = en;
    c.win_vbounds   = vb;
    c.win_in_masks  = im;
    c.win_out_masks = om;
    c.blend_ctrl    = bc;
    c.blend_weights = bw;
    c.bright_weight = br;
    c.backdrop      = bd;
    return c;
  endfunction

  // flags: {object window, window 1 column, window 0 column}
  task automatic add_pixel(input logic [7:0] row, input logic [31:0] b0, input logic [31:0] b1,
                           input logic [31:0] b2, input logic [31:0] sp,
                           input logic [2:0] flags);
    pixel_t px;
    px.scanline = row;
    px.bg0      = b0;
    px.bg1      = b1;
    px.bg2      = b2;
    px.sprite   = sp;
    {px.obj_win, px.win1_col, px.win0_col} = flags;
    pending_pixels.push_back(px);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Writes all eight registers back to back; only called with the pipe empty
  task automatic apply_settings(input mixer_cfg_t c);
    logic [31:0] word [8];
    word[CFG_WIN_ENABLE]    = 32'(c.win_enable);
    word[CFG_WIN_VBOUNDS]   = c.win_vbounds;
    word[CFG_WIN_IN_MASKS]  = 32'(c.win_in_masks);
    word[CFG_WIN_OUT_MASKS] = 32'(c.win_out_masks);
    word[CFG_BLEND_CTRL]    = 32'(c.blend_ctrl);
    word[CFG_BLEND_WEIGHTS] = 32'(c.blend_weights);
    word[CFG_BRIGHT_WEIGHT] = 32'(c.bright_weight);
    word[CFG_BACKDROP]      = 32'(c.backdrop);
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= word[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    mix_cfg = c;
  endtask

  // Sender holds off until every launched beat has come back
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || sent_count != results_seen)
      @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver
  // ---------------------------------------------------------------------------
  pixel_t      on_wire;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;

  always @(posedge clk_i) begin : pixel_driver
    logic busy;
    if (rst_ni) begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_pixels.push_back(composite_pixel(on_wire, mix_cfg));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          on_wire = pending_pixels.pop_front();
          sent_count++;
          scanline_i         <= on_wire.scanline;
          bg0_word_i         <= on_wire.bg0;
          bg1_word_i         <= on_wire.bg1;
          bg2_word_i         <= on_wire.bg2;
          sprite_word_i      <= on_wire.sprite;
          in_object_window_i <= on_wire.obj_win;
          in_win0_column_i   <= on_wire.win0_col;
          in_win1_column_i   <= on_wire.win1_col;
          in_valid_i         <= 1'b1;
          send_gap           <= pick_gap(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // occasional bursts with no gaps at all
      if (send_calm != 0) send_calm <= send_calm - 1;
      else if ($urandom_range(0, 63) == 0) send_calm <= $urandom_range(20, 60);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stalls
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned recv_calm = 0;

  always @(posedge clk_i) begin : result_monitor
    logic [31:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, mixed_pixel %h", mixed_pixel_o));
        end else begin
          want = expected_pixels.pop_front();
          if (mixed_pixel_o !== want)
            report_mismatch($sformatf("beat %0d mixed_pixel got %h want %h",
                                      results_seen, mixed_pixel_o, want));
        end
        results_seen++;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left <= pick_gap(recv_calm);
      end
      if (recv_calm != 0) recv_calm <= recv_calm - 1;
      else if ($urandom_range(0, 63) == 0) recv_calm <= $urandom_range(20, 60);
    end
  end

  // Watchdog: too long with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    mixer_cfg_t settings;
    logic [31:0] b0;
    logic [31:0] b1;
    logic [31:0] b2;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Alpha setup: win0 rows 0x00..0x1F, win1 wraps 0xF0..0x07
    apply_settings(settings_of(2'b11, 32'hF008_0020, 16'h133F, 16'h2427, 14'h2651,
                               16'h140C, 5'd9, 15'h1234));
    add_pixel(8'h00, '0, '0, '0, '0, 3'b000);
    add_pixel(8'hFF, '1, '1, '1, '1, 3'b111);
    b0 = 32'h4000_0000;
    b1 = 32'h2000_7C00;
    b2 = 32'h2800_0000;
    // semi-transparent sprite over BG1: window edges
    add_pixel(8'h00, b0, b1, b2, 32'h0801_001F, 3'b001);
    add_pixel(8'h1F, b0, b1, b2, 32'h0801_001F, 3'b001);
    add_pixel(8'h20, b0, b1, b2, 32'h0801_001F, 3'b001);
    add_pixel(8'hF0, b0, b1, b2, 32'h0801_001F, 3'b010);
    add_pixel(8'h07, b0, b1, b2, 32'h0801_001F, 3'b010);
    add_pixel(8'h08, b0, b1, b2, 32'h0801_001F, 3'b010);
    // opaque sprite: window 0 over window 1 over object window
    add_pixel(8'h05, b0, b1, b2, 32'h0800_03E0, 3'b011);
    add_pixel(8'h05, b0, b1, b2, 32'h0800_03E0, 3'b010);
    add_pixel(8'h40, b0, b1, b2, 32'h0800_03E0, 3'b100);
    add_pixel(8'hF8, b0, b1, b2, 32'h0800_03E0, 3'b110);
    // BG0 against the backdrop on the whole word
    add_pixel(8'h40, 32'h3000_0100, 32'h4000_0000, 32'h5000_0000, 32'h1000_0000, 3'b000);
    add_pixel(8'h40, 32'h3000_1235, 32'h4000_0000, 32'h5000_0000, 32'h1000_0000, 3'b000);
    add_pixel(8'h40, 32'h1000_0005, 32'h1000_0000, 32'h5000_0000, 32'h1000_0000, 3'b000);
    // semi-transparent BG0 finds itself underneath
    add_pixel(8'h40, 32'h0C01_7FFF, b1, 32'h5000_0000, 32'h1000_0000, 3'b000);
    wait_idle();

    // Brighten: win0 always inside, win1 never
    apply_settings(settings_of(2'b01, 32'h3030_E8E8, 16'h0031, 16'h0000, 14'h00BF,
                               16'h0000, 5'd31, 15'h0000));
    b1 = 32'hFF00_0000;
    add_pixel(8'h00, 32'h0500_0421, b1, b1, b1, 3'b001);
    add_pixel(8'hFF, 32'h0500_0421, b1, b1, 32'h0201_5555, 3'b001);
    add_pixel(8'h80, 32'h0500_0421, b1, b1, 32'h0201_5555, 3'b000);
    wait_idle();

    // Darken: window 1 only, wrapped rows
    apply_settings(settings_of(2'b10, 32'h4010_0000, 16'h3100, 16'h0000, 14'h00FF,
                               16'h0000, 5'd5, 15'h7FFF));
    add_pixel(8'h50, 32'h0500_7FFF, b1, b1, b1, 3'b010);
    add_pixel(8'h20, 32'h0500_7FFF, b1, b1, b1, 3'b010);
    add_pixel(8'h00, 32'h0500_7FFF, b1, b1, 32'h0101_1234, 3'b010);
    wait_idle();

    // Random phases: all zeros, all ones, then random settings per effect
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) settings = '0;
      else if (ph == 1) settings = '1;
      else settings = random_settings(fx_e'(ph % 4));
      apply_settings(settings);
      repeat (50) pending_pixels.push_back(random_pixel());
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", expected_pixels.size()));
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/wlbm_pkg.sv
design/wlbm_layer_sel.sv
design/windowed_layer_blend_mixer.sv
test/tb_windowed_layer_blend_mixer.sv
